// ----- src/assert_macros.svh -----
// Shared assertion macros for the framer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CRCFRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CRCFRM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/crcfrm_pkg.sv -----
`default_nettype none

package crcfrm_pkg;

  localparam int MAX_PAYLOAD = 255;
  localparam int RES_DEPTH   = 5;
  localparam int CFG_DATA_W  = 16;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] PREAMBLE = 8'h00;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_OK_STATUS = 1'b0;
  localparam cfg_idx_t CFG_CAPACITY  = 1'b1;

  localparam logic [1:0] CMD_BEGIN   = 2'd0;
  localparam logic [1:0] CMD_PAYLOAD = 2'd1;
  localparam logic [1:0] CMD_RESP    = 2'd2;

  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_DATA    = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  localparam logic [1:0] V_OK     = 2'd0;
  localparam logic [1:0] V_CRC    = 2'd1;
  localparam logic [1:0] V_STATUS = 2'd2;
  localparam logic [1:0] V_NONE   = 2'd3;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  out_kind;
    logic [1:0]  verdict;
    logic [7:0]  device_status;
    logic [15:0] data_count;
    logic        last;
  } res_t;

  localparam res_t RES_NONE = '{out_byte: 8'h00, out_kind: KIND_TX, verdict: V_NONE,
                                device_status: 8'h00, data_count: 16'h0000, last: 1'b0};

  // One byte of CRC-8, poly 0x07, MSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] x;
    x = c ^ b;
    for (int i = 0; i < 8; i++) begin
      x = x[7] ? ({x[6:0], 1'b0} ^ CRC_POLY) : {x[6:0], 1'b0};
    end
    return x;
  endfunction

  function automatic res_t tx_res(input logic [7:0] b, input logic lst);
    res_t r;
    r = RES_NONE;
    r.out_byte = b;
    r.last = lst;
    return r;
  endfunction

  function automatic res_t data_res(input logic [7:0] b);
    res_t r;
    r = RES_NONE;
    r.out_byte = b;
    r.out_kind = KIND_DATA;
    return r;
  endfunction

  function automatic res_t verdict_res(input logic [1:0] v, input logic [7:0] st,
                                       input logic [15:0] cnt);
    res_t r;
    r = RES_NONE;
    r.out_kind = KIND_VERDICT;
    r.verdict = v;
    r.device_status = st;
    r.data_count = cnt;
    r.last = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/crcfrm_in_if.sv -----
`default_nettype none

interface crcfrm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] command_code;
  logic [7:0] payload_length;
  logic [7:0] in_byte;

  modport source (output valid, command, command_code, payload_length, in_byte,
                  input ready);
  modport sink (input valid, command, command_code, payload_length, in_byte,
                output ready);
endinterface

`default_nettype wire

// ----- src/crcfrm_out_if.sv -----
`default_nettype none

interface crcfrm_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  out_kind;
  logic [1:0]  verdict;
  logic [7:0]  device_status;
  logic [15:0] data_count;
  logic        last;

  modport source (output valid, out_byte, out_kind, verdict, device_status, data_count,
                  last, input ready);
  modport sink (input valid, out_byte, out_kind, verdict, device_status, data_count,
                last, output ready);
endinterface

`default_nettype wire

// ----- src/crc8_command_response_framer.sv -----
// CRC-8 (poly 0x07, init 0) command framer and response checker. Each accepted
// word is decoded combinationally and its results (zero to five words) are
// loaded into a five-entry result buffer that drains one word per cycle while
// the output is ready; a new input word is taken once the buffer holds at most
// one word that is leaving in the same cycle. So response words and all but the
// last payload word run at one per cycle while the output is ready; the last
// payload word (with CRC) and a begin word (with header) hold the input until
// the buffer drains. Response data is passed on before the verdict; drop it
// when the verdict is not ok. The user must write registers via cfg_we/cfg_idx/
// cfg_wdata only while the block is idle, which the block does not enforce.
`default_nettype none

module crc8_command_response_framer (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire crcfrm_pkg::cfg_idx_t             cfg_idx,
  input  wire logic [crcfrm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  crcfrm_in_if.sink                             in_ch,
  crcfrm_out_if.source                          out_ch
);
  import crcfrm_pkg::*;
  `include "assert_macros.svh"

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_BODY    = 2'd2;

  localparam int CNT_W = $clog2(RES_DEPTH + 1);

  // configuration
  logic [7:0]  ok_status_r;
  logic [15:0] capacity_r;

  // frame state
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  payload_left_r, payload_left_nxt;
  logic [1:0]  hdr_idx_r, hdr_idx_nxt;
  logic [15:0] resp_len_r, resp_len_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  held_status_r, held_status_nxt;
  logic [15:0] passed_r, passed_nxt;

  // result buffer, head at entry 0
  res_t             res_r [RES_DEPTH];
  res_t             new_res [RES_DEPTH];
  logic [CNT_W-1:0] cnt_r, new_cnt;

  logic        in_acc, out_pop;
  logic [7:0]  plen_c;
  logic [15:0] tot;
  logic [7:0]  crc_h, crc_l, crc_cmd, crc_in, crc_z;
  logic [1:0]  vd;

  assign out_pop     = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (cnt_r == '0) || (cnt_r == CNT_W'(1) && out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign plen_c = (16'(in_ch.payload_length) > 16'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD)
                                                                  : in_ch.payload_length;
  assign tot     = {8'h00, plen_c} + 16'd1;
  assign crc_h   = crc8_step(8'h00, tot[15:8]);
  assign crc_l   = crc8_step(crc_h, tot[7:0]);
  assign crc_cmd = crc8_step(crc_l, in_ch.command_code);
  assign crc_in  = crc8_step(crc_r, in_ch.in_byte);
  assign crc_z   = crc8_step(8'h00, in_ch.in_byte);

  always_comb begin
    for (int i = 0; i < RES_DEPTH; i++) begin
      new_res[i] = RES_NONE;
    end
    new_cnt          = '0;
    phase_nxt        = phase_r;
    crc_nxt          = crc_r;
    payload_left_nxt = payload_left_r;
    hdr_idx_nxt      = hdr_idx_r;
    resp_len_nxt     = resp_len_r;
    bytes_left_nxt   = bytes_left_r;
    held_status_nxt  = held_status_r;
    passed_nxt       = passed_r;
    vd               = V_OK;
    case (in_ch.command)
      CMD_BEGIN: begin
        hdr_idx_nxt    = 2'd0;
        bytes_left_nxt = '0;
        resp_len_nxt   = '0;
        crc_nxt        = crc_cmd;
        new_res[0]     = tx_res(PREAMBLE, 1'b0);
        new_res[1]     = tx_res(tot[15:8], 1'b0);
        new_res[2]     = tx_res(tot[7:0], 1'b0);
        new_res[3]     = tx_res(in_ch.command_code, 1'b0);
        payload_left_nxt = plen_c;
        if (plen_c == 8'h00) begin
          new_res[4] = tx_res(crc_cmd, 1'b1);
          new_cnt    = CNT_W'(5);
          phase_nxt  = PH_IDLE;
        end else begin
          new_cnt   = CNT_W'(4);
          phase_nxt = PH_PAYLOAD;
        end
      end
      CMD_PAYLOAD: begin
        if (phase_r == PH_PAYLOAD) begin
          crc_nxt          = crc_in;
          new_res[0]       = tx_res(in_ch.in_byte, 1'b0);
          new_cnt          = CNT_W'(1);
          payload_left_nxt = payload_left_r - 8'd1;
          if (payload_left_r == 8'd1) begin
            new_res[1]  = tx_res(crc_in, 1'b1);
            new_cnt     = CNT_W'(2);
            phase_nxt   = PH_IDLE;
            hdr_idx_nxt = 2'd0;
          end
        end
      end
      CMD_RESP: begin
        if (phase_r == PH_IDLE) begin
          if (hdr_idx_r == 2'd0) begin
            crc_nxt         = crc_z;
            resp_len_nxt    = {in_ch.in_byte, 8'h00};
            passed_nxt      = '0;
            held_status_nxt = '0;
            hdr_idx_nxt     = 2'd1;
          end else if (hdr_idx_r == 2'd1) begin
            crc_nxt      = crc_in;
            resp_len_nxt = {resp_len_r[15:8], in_ch.in_byte};
            hdr_idx_nxt  = 2'd2;
          end else begin
            held_status_nxt = in_ch.in_byte;
            if (resp_len_r == '0) begin
              // status byte doubles as the CRC
              if (crc_r != in_ch.in_byte) begin
                vd = V_CRC;
              end else if (in_ch.in_byte != ok_status_r) begin
                vd = V_STATUS;
              end
              new_res[0]  = verdict_res(vd, in_ch.in_byte, passed_r);
              new_cnt     = CNT_W'(1);
              phase_nxt   = PH_IDLE;
              hdr_idx_nxt = 2'd0;
            end else begin
              crc_nxt        = crc_in;
              bytes_left_nxt = resp_len_r;
              phase_nxt      = PH_BODY;
              hdr_idx_nxt    = 2'd0;
            end
          end
        end else if (phase_r == PH_BODY) begin
          if (bytes_left_r > 16'd1) begin
            crc_nxt        = crc_in;
            bytes_left_nxt = bytes_left_r - 16'd1;
            if (passed_r < capacity_r) begin
              new_res[0] = data_res(in_ch.in_byte);
              new_cnt    = CNT_W'(1);
              passed_nxt = passed_r + 16'd1;
            end
          end else begin
            bytes_left_nxt = '0;
            if (crc_r != in_ch.in_byte) begin
              vd = V_CRC;
            end else if (held_status_r != ok_status_r) begin
              vd = V_STATUS;
            end
            new_res[0]  = verdict_res(vd, held_status_r, passed_r);
            new_cnt     = CNT_W'(1);
            phase_nxt   = PH_IDLE;
            hdr_idx_nxt = 2'd0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_status_r <= 8'h00;
      capacity_r  <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_OK_STATUS: ok_status_r <= cfg_wdata[7:0];
        CFG_CAPACITY:  capacity_r  <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      crc_r          <= '0;
      payload_left_r <= '0;
      hdr_idx_r      <= '0;
      resp_len_r     <= '0;
      bytes_left_r   <= '0;
      held_status_r  <= '0;
      passed_r       <= '0;
    end else if (in_acc) begin
      phase_r        <= phase_nxt;
      crc_r          <= crc_nxt;
      payload_left_r <= payload_left_nxt;
      hdr_idx_r      <= hdr_idx_nxt;
      resp_len_r     <= resp_len_nxt;
      bytes_left_r   <= bytes_left_nxt;
      held_status_r  <= held_status_nxt;
      passed_r       <= passed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc) begin
      cnt_r <= new_cnt;
    end else if (out_pop) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < RES_DEPTH; i++) begin
        res_r[i] <= new_res[i];
      end
    end else if (out_pop) begin
      for (int i = 0; i < RES_DEPTH - 1; i++) begin
        res_r[i] <= res_r[i+1];
      end
    end
  end

  assign out_ch.valid         = (cnt_r != '0);
  assign out_ch.out_byte      = res_r[0].out_byte;
  assign out_ch.out_kind      = res_r[0].out_kind;
  assign out_ch.verdict       = res_r[0].verdict;
  assign out_ch.device_status = res_r[0].device_status;
  assign out_ch.data_count    = res_r[0].data_count;
  assign out_ch.last          = res_r[0].last;

  `CRCFRM_ASSERT(a_acc_buf_drained, in_acc |-> cnt_r <= CNT_W'(1), "word taken over pending results")
  `CRCFRM_ASSERT(a_body_left, phase_r == PH_BODY |-> bytes_left_r != '0, "body with no bytes left")
  `CRCFRM_ASSERT(a_payload_left, phase_r == PH_PAYLOAD |-> payload_left_r != '0, "payload phase with none left")
  `CRCFRM_ASSERT(a_last_kind, out_ch.valid && out_ch.last |-> out_ch.out_kind != KIND_DATA, "last on data word")
  `CRCFRM_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> cnt_r == '0, "result buffer not empty after reset")

endmodule

`default_nettype wire
